// ===== src/trg_pkg.sv =====
// shared types, constants, font table and helper functions for the text glyph rasterizer
package trg_pkg;

    localparam int MAX_PITCH_DEF  = 1280;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam logic [10:0] WIDTH_RST  = 11'd240;
    localparam logic [10:0] HEIGHT_RST = 11'd160;
    localparam logic [10:0] PITCH_RST  = 11'd240;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PITCH  = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int GLYPH_BITS = 35;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_BLANK = 2'd1,
        KIND_START = 2'd2
    } t_kind;

    typedef struct packed {
        logic [5:0]  glyph;
        logic [10:0] base_y;
        logic [10:0] base_x;
    } t_cmd;

    // column 0 in the top byte, bit 0 of each byte is the top pixel
    localparam logic [39:0] FONT [64] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040
    };

    function automatic logic [5:0] glyph_index(input logic [7:0] code);
        logic [7:0] c;
        logic [7:0] d;
        c = code;
        if (c >= 8'h61 && c <= 8'h7A) begin
            c = c - 8'h20;
        end
        if (c < 8'h20 || c > 8'h5F) begin
            c = 8'h3F;
        end
        d = c - 8'h20;
        return d[5:0];
    endfunction

    // bit x*7+y is glyph column x, row y
    function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [5:0] idx);
        logic [39:0]            f;
        logic [GLYPH_BITS-1:0]  b;
        f = FONT[idx];
        b = '0;
        for (int x = 0; x < 5; x++) begin
            b[x*7 +: 7] = f[32 - 8*x +: 7];
        end
        return b;
    endfunction

    // (w - 4) / 6 as a reciprocal multiply, exact below 2048
    function automatic logic [7:0] count_columns(input logic [10:0] w);
        logic [10:0] t;
        logic [20:0] p;
        logic [8:0]  q;
        t = w - 11'd4;
        p = {10'b0, t} * 21'd683;
        q = p[20:12];
        if (w < 11'd4) begin
            return 8'd0;
        end else if (q > 9'd255) begin
            return 8'd255;
        end
        return q[7:0];
    endfunction

    // (h - 4) / 9 as a reciprocal multiply, exact below 2048
    function automatic logic [6:0] count_rows(input logic [10:0] h);
        logic [10:0] t;
        logic [21:0] p;
        logic [7:0]  q;
        t = h - 11'd4;
        p = {11'b0, t} * 22'd1821;
        q = p[21:14];
        if (h < 11'd4) begin
            return 7'd0;
        end else if (q > 8'd127) begin
            return 7'd127;
        end
        return q[6:0];
    endfunction

endpackage

// ===== src/trg_front.sv =====
// front end: accepts items, tracks text row and column, queues glyph draws
module trg_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_char_code,
    input  logic              i_last_in_line,
    input  logic [7:0]        i_columns,
    input  logic [6:0]        i_rows,
    input  logic              i_full,
    output logic              o_push,
    output trg_pkg::t_cmd     o_cmd
);
    import trg_pkg::*;

    logic [6:0] r_row;
    logic [7:0] r_col;
    logic [6:0] n_row;
    logic [7:0] n_col;
    logic       w_accept;
    logic       w_room;
    logic [8:0] w_col_inc;
    logic [5:0] w_glyph;

    assign o_in_ready = !i_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_room     = (i_columns != 8'd0) && (i_rows != 7'd0);
    assign w_col_inc  = {1'b0, r_col} + 9'd1;
    assign w_glyph    = glyph_index(i_char_code);

    assign o_cmd.glyph  = w_glyph;
    assign o_cmd.base_y = 11'd2 + {1'b0, r_row, 3'b000} + {4'b0, r_row};
    assign o_cmd.base_x = 11'd2 + {1'b0, r_col, 2'b00} + {2'b0, r_col, 1'b0};

    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        o_push = 1'b0;
        if (w_accept && w_room) begin
            unique case (i_kind)
                KIND_START: begin
                    n_row = 7'd0;
                    n_col = 8'd0;
                end
                KIND_BLANK: begin
                    if (r_row < i_rows) begin
                        n_row = r_row + 7'd1;
                        n_col = 8'd0;
                    end
                end
                KIND_CHAR: begin
                    if (r_row < i_rows) begin
                        // space has no ink
                        o_push = (w_glyph != 6'd0);
                        if (i_last_in_line || w_col_inc >= {1'b0, i_columns}) begin
                            n_row = r_row + 7'd1;
                            n_col = 8'd0;
                        end else begin
                            n_col = w_col_inc[7:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= 7'd0;
            r_col <= 8'd0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

// ===== src/trg_queue.sv =====
// short command queue between front end and pixel walker
module trg_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  trg_pkg::t_cmd     i_cmd,
    output logic              o_full,
    output logic              o_valid,
    output trg_pkg::t_cmd     o_cmd,
    input  logic              i_pop
);
    import trg_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(w_pop);
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

endmodule

// ===== src/trg_back.sv =====
// back end: walks the glyph bits and emits one pixel offset per set bit
module trg_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [10:0]       i_pitch,
    input  logic              i_q_valid,
    input  trg_pkg::t_cmd     i_q_cmd,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [20:0]       o_pixel_offset,
    output logic              o_last
);
    import trg_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_back_state;

    t_back_state           r_state;
    t_back_state           n_state;
    logic [GLYPH_BITS-1:0] r_bits;
    logic [2:0]            r_y;
    logic [10:0]           r_x_off;
    logic [20:0]           r_line;
    logic [20:0]           r_base_line;
    logic                  r_out_valid;
    logic [20:0]           r_out_offset;
    logic                  r_out_last;
    logic                  w_advance;
    logic                  w_step;
    logic                  w_final;
    logic [21:0]           w_prod;

    assign w_advance = !r_out_valid || i_out_ready;
    assign w_step    = (r_state == S_RUN) && w_advance;
    assign w_final   = (r_bits[GLYPH_BITS-1:1] == '0);
    assign o_pop     = (r_state == S_IDLE) && i_q_valid;
    assign w_prod    = {11'b0, i_q_cmd.base_y} * {11'b0, i_pitch};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_advance && w_final) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_advance) begin
                r_out_valid <= w_step && r_bits[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bits      <= glyph_bits(i_q_cmd.glyph);
            r_y         <= 3'd0;
            r_x_off     <= i_q_cmd.base_x;
            r_line      <= w_prod[20:0];
            r_base_line <= w_prod[20:0];
        end else if (w_step) begin
            r_bits <= r_bits >> 1;
            if (r_y == 3'd6) begin
                r_y     <= 3'd0;
                r_x_off <= r_x_off + 11'd1;
                r_line  <= r_base_line;
            end else begin
                r_y    <= r_y + 3'd1;
                r_line <= r_line + {10'b0, i_pitch};
            end
        end
        if (w_step) begin
            r_out_offset <= r_line + {10'b0, r_x_off};
            r_out_last   <= w_final;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_offset = r_out_offset;
    assign o_last         = r_out_last;

    a_run_has_ink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_bits != '0))
        else $error("walker running on an empty glyph");

    a_emit_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RUN))
        else $error("pixel emitted outside the walk");

endmodule

// ===== src/text_glyph_rasterizer.sv =====
// top level of the text glyph rasterizer: register file, front end, queue and pixel walker
//
// Input channel (i_in_valid / o_in_ready) takes one transaction per item:
// i_kind selects a character, a blank line or start of message. The front
// end folds the character code, updates the text row and column in the
// cycle it is taken and queues one draw command for each inked glyph.
// Output channel (o_out_valid / i_out_ready) gives one transaction per
// white pixel: o_pixel_offset, with o_last on the final pixel of a glyph.
// The pixel walker first loads a command (glyph fetch and the row times
// pitch product), then steps one glyph bit per cycle while the output is
// not stalled, up to the last inked bit; the first pixel passes the load
// registers and then the output register. A two-entry command queue lets
// the front end keep taking items while the walker draws. When the receiver
// stalls the output register holds and the walker stops; once the queue
// fills the input stalls too. Reset clears text row and column and loads
// 240 x 160 with pitch 240. The user must write registers over the APB port
// only while the block is idle; the block itself does not enforce this.
module text_glyph_rasterizer #(
    parameter int MAX_PITCH  = trg_pkg::MAX_PITCH_DEF,
    parameter int MAX_HEIGHT = trg_pkg::MAX_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_in_line,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [20:0] o_pixel_offset,
    output logic        o_last
);
    import trg_pkg::*;

    logic [10:0] r_width;
    logic [10:0] r_height;
    logic [10:0] r_pitch;
    logic [7:0]  r_columns;
    logic [6:0]  r_rows;
    logic        w_wr;
    logic [10:0] w_wdata;
    logic [10:0] w_clamp_pitch;
    logic [10:0] w_clamp_height;
    logic        w_push;
    logic        w_full;
    logic        w_q_valid;
    logic        w_pop;
    t_cmd        w_cmd_in;
    t_cmd        w_cmd_out;

    assign pready         = 1'b1;
    assign w_wr           = psel && penable && pwrite && pready;
    assign w_wdata        = pwdata[10:0];
    assign w_clamp_pitch  = (int'(w_wdata) > MAX_PITCH) ? 11'(MAX_PITCH) : w_wdata;
    assign w_clamp_height = (int'(w_wdata) > MAX_HEIGHT) ? 11'(MAX_HEIGHT) : w_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WIDTH_RST;
            r_height  <= HEIGHT_RST;
            r_pitch   <= PITCH_RST;
            r_columns <= count_columns(WIDTH_RST);
            r_rows    <= count_rows(HEIGHT_RST);
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_WIDTH: begin
                    r_width   <= w_clamp_pitch;
                    r_columns <= count_columns(w_clamp_pitch);
                end
                REG_HEIGHT: begin
                    r_height <= w_clamp_height;
                    r_rows   <= count_rows(w_clamp_height);
                end
                REG_PITCH: begin
                    r_pitch <= w_clamp_pitch;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = {21'b0, r_width};
            REG_HEIGHT: prdata = {21'b0, r_height};
            REG_PITCH:  prdata = {21'b0, r_pitch};
            default:    prdata = 32'd0;
        endcase
    end

    trg_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_char_code    (i_char_code),
        .i_last_in_line (i_last_in_line),
        .i_columns      (r_columns),
        .i_rows         (r_rows),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_cmd          (w_cmd_in)
    );

    trg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_cmd_out),
        .i_pop   (w_pop)
    );

    trg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pitch        (r_pitch),
        .i_q_valid      (w_q_valid),
        .i_q_cmd        (w_cmd_out),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_offset (o_pixel_offset),
        .o_last         (o_last)
    );

endmodule

// ===== bench/glyph_pixel_checker.sv =====
// checker for the text glyph rasterizer: tracks registers and text position, predicts and compares pixels
`timescale 1ns / 1ps

module glyph_pixel_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_in_line,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [20:0] i_pixel_offset,
    input  logic        i_last,
    output int          o_pending,
    output int          o_fails,
    output int          o_pixels
);
    import trg_pkg::*;

    typedef struct packed {
        logic [20:0] offset;
        logic        last;
    } t_pixel;

    // five column bytes per glyph, column 0 in the top byte, bit 0 is the top pixel
    localparam logic [39:0] GLYPH_FONT [64] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040
    };

    int     frame_w;
    int     frame_h;
    int     row_pitch;
    int     text_row;
    int     text_col;
    t_pixel pixels_due[$];

    function automatic int saturate(input logic [10:0] value, input int limit);
        return (int'(value) > limit) ? limit : int'(value);
    endfunction

    task automatic report_mismatch(input string msg);
        if (o_fails < 100) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        o_fails++;
    endtask

    function automatic void draw_item(input logic [1:0] kind, input logic [7:0] code,
                                      input logic eol);
        int          cols;
        int          rows;
        int          start_n;
        int          off;
        logic [7:0]  c;
        logic [5:0]  gidx;
        logic [39:0] glyph;
        logic [7:0]  column_bits;
        t_pixel      px;
        cols = (frame_w < 4) ? 0 : (frame_w - 4) / 6;
        rows = (frame_h < 4) ? 0 : (frame_h - 4) / 9;
        if (cols > 255) cols = 255;
        if (rows > 127) rows = 127;
        if (cols == 0 || rows == 0) return;
        if (kind == KIND_START) begin
            text_row = 0;
            text_col = 0;
            return;
        end
        if (kind != KIND_CHAR && kind != KIND_BLANK) return;
        if (text_row >= rows) return;
        if (kind == KIND_BLANK) begin
            text_row++;
            text_col = 0;
            return;
        end
        c = code;
        if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
        if (c < 8'h20 || c > 8'h5F) c = 8'h3F;
        gidx = 6'(c - 8'h20);
        glyph = GLYPH_FONT[gidx];
        start_n = pixels_due.size();
        for (int x = 0; x < 5; x++) begin
            column_bits = glyph[39 - 8*x -: 8];
            for (int y = 0; y < 7; y++) begin
                if (column_bits[y]) begin
                    off = (2 + text_row * 9 + y) * row_pitch + 2 + text_col * 6 + x;
                    px.offset = off[20:0];
                    px.last = 1'b0;
                    pixels_due.push_back(px);
                end
            end
        end
        if (pixels_due.size() > start_n) begin
            px = pixels_due.pop_back();
            px.last = 1'b1;
            pixels_due.push_back(px);
        end
        text_col++;
        if (eol || text_col >= cols) begin
            text_row++;
            text_col = 0;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_pixel want;
        if (!i_rst_n) begin
            frame_w = int'(WIDTH_RST);
            frame_h = int'(HEIGHT_RST);
            row_pitch = int'(PITCH_RST);
            text_row = 0;
            text_col = 0;
            o_fails = 0;
            o_pixels = 0;
            pixels_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_WIDTH:  frame_w = saturate(pwdata[10:0], MAX_PITCH_DEF);
                    REG_HEIGHT: frame_h = saturate(pwdata[10:0], MAX_HEIGHT_DEF);
                    REG_PITCH:  row_pitch = saturate(pwdata[10:0], MAX_PITCH_DEF);
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                o_pixels++;
                if (pixels_due.size() == 0) begin
                    report_mismatch($sformatf("pixel %0d (last %0b) with none expected",
                                              i_pixel_offset, i_last));
                end else begin
                    want = pixels_due.pop_front();
                    if (i_pixel_offset !== want.offset) begin
                        report_mismatch($sformatf("pixel offset %0d, expected %0d",
                                                  i_pixel_offset, want.offset));
                    end
                    if (i_last !== want.last) begin
                        report_mismatch($sformatf("last %0b at offset %0d, expected %0b",
                                                  i_last, want.offset, want.last));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                draw_item(i_kind, i_char_code, i_last_in_line);
            end
        end
        o_pending = pixels_due.size();
    end

endmodule

// ===== bench/tb_text_glyph_rasterizer.sv =====
// testbench top for the text glyph rasterizer: clock, reset, register writes, stimulus and verdict
`timescale 1ns / 1ps

module tb_text_glyph_rasterizer;
    import trg_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] code;
        logic       eol;
    } t_item;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_HALF,
        RX_SPARSE,
        RX_MOSTLY
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_kind = KIND_CHAR;
    logic [7:0]  i_char_code = '0;
    logic        i_last_in_line = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [20:0] o_pixel_offset;
    logic        o_last;

    logic        hold_off = 1'b0;
    logic        pressure_go = 1'b0;
    t_rx_mode    rx_mode = RX_FREE;
    int          rx_left = 0;
    int          pixels_pending;
    int          fail_count;
    int          pixels_seen;
    int          items_sent = 0;
    int          settings_used = 0;
    t_item       text_items[$];

    text_glyph_rasterizer dut (.*);

    glyph_pixel_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_char_code    (i_char_code),
        .i_last_in_line (i_last_in_line),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_pixel_offset (o_pixel_offset),
        .i_last         (o_last),
        .o_pending      (pixels_pending),
        .o_fails        (fail_count),
        .o_pixels       (pixels_seen)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    always @(negedge i_clk) begin : rx_pattern
        logic pick;
        case (rx_mode)
            RX_FREE:   pick = 1'b1;
            RX_HALF:   pick = 1'($urandom_range(0, 1));
            RX_SPARSE: pick = ($urandom_range(0, 3) == 0);
            default:   pick = ($urandom_range(0, 4) != 0);
        endcase
        if (rx_left == 0) begin
            rx_left <= $urandom_range(20, 200);
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
        end else begin
            rx_left <= rx_left - 1;
        end
        i_out_ready <= hold_off ? 1'b0 : pick;
    end

    // long output stall while the sender keeps offering, so the command queue fills
    initial begin
        wait (pressure_go);
        repeat (40) @(negedge i_clk);
        hold_off <= 1'b1;
        repeat (600) @(negedge i_clk);
        hold_off <= 1'b0;
    end

    function automatic t_item glyph_item(input logic [1:0] kind, input logic [7:0] code,
                                         input logic eol);
        t_item it;
        it.kind = kind;
        it.code = code;
        it.eol = eol;
        return it;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] value);
        paddr <= {idx, 2'b00};
        pwdata <= (32'($urandom) & 32'hFFFF_F800) | {21'b0, value};
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic program_frame(input logic [10:0] w, input logic [10:0] h,
                                 input logic [10:0] p);
        while (pixels_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_PITCH, p);
        settings_used++;
    endtask

    // sends the queued items in bursts with random gaps
    task automatic play_items();
        int idx;
        int burst;
        int gap;
        idx = 0;
        while (idx < text_items.size()) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && idx < text_items.size()) begin
                i_in_valid <= 1'b1;
                i_kind <= text_items[idx].kind;
                i_char_code <= text_items[idx].code;
                i_last_in_line <= text_items[idx].eol;
                @(posedge i_clk);
                while (!o_in_ready) @(posedge i_clk);
                @(negedge i_clk);
                idx++;
                burst--;
                items_sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_in_valid <= 1'b0;
        text_items.delete();
    endtask

    initial begin : stimulus
        int         roll;
        int         w;
        logic [7:0] code;
        logic       eol;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset geometry: case folding, out-of-range codes, space, blank line, unused kind
        text_items.push_back(glyph_item(KIND_START, 8'h00, 1'b0));
        text_items.push_back(glyph_item(KIND_CHAR, 8'h41, 1'b0));
        text_items.push_back(glyph_item(KIND_CHAR, 8'h61, 1'b0));
        text_items.push_back(glyph_item(KIND_CHAR, 8'h7A, 1'b0));
        text_items.push_back(glyph_item(KIND_CHAR, 8'h00, 1'b0));
        text_items.push_back(glyph_item(KIND_CHAR, 8'hFF, 1'b0));
        text_items.push_back(glyph_item(KIND_CHAR, 8'h20, 1'b0));
        text_items.push_back(glyph_item(KIND_CHAR, 8'h5F, 1'b0));
        text_items.push_back(glyph_item(KIND_CHAR, 8'h60, 1'b0));
        text_items.push_back(glyph_item(KIND_CHAR, 8'h7B, 1'b0));
        text_items.push_back(glyph_item(KIND_CHAR, 8'h23, 1'b0));
        text_items.push_back(glyph_item(KIND_CHAR, 8'h7F, 1'b1));
        text_items.push_back(glyph_item(KIND_CHAR, 8'h42, 1'b0));
        text_items.push_back(glyph_item(KIND_BLANK, 8'hFF, 1'b1));
        text_items.push_back(glyph_item(KIND_UNUSED, 8'hAA, 1'b1));
        text_items.push_back(glyph_item(KIND_START, 8'h55, 1'b1));
        text_items.push_back(glyph_item(KIND_CHAR, 8'h48, 1'b0));
        text_items.push_back(glyph_item(KIND_CHAR, 8'h45, 1'b0));
        text_items.push_back(glyph_item(KIND_CHAR, 8'h4C, 1'b0));
        text_items.push_back(glyph_item(KIND_CHAR, 8'h4C, 1'b0));
        play_items();

        // width shrinks under the current column: drawn in place, then the line wraps
        program_frame(11'd16, 11'd160, 11'd240);
        text_items.push_back(glyph_item(KIND_CHAR, 8'h4F, 1'b0));
        text_items.push_back(glyph_item(KIND_CHAR, 8'h4B, 1'b0));
        play_items();

        // single text row, already passed by the text position: items dropped until a new message
        program_frame(11'd240, 11'd13, 11'd240);
        text_items.push_back(glyph_item(KIND_CHAR, 8'h41, 1'b1));
        text_items.push_back(glyph_item(KIND_CHAR, 8'h42, 1'b0));
        text_items.push_back(glyph_item(KIND_BLANK, 8'h00, 1'b0));
        text_items.push_back(glyph_item(KIND_START, 8'h00, 1'b0));
        text_items.push_back(glyph_item(KIND_CHAR, 8'h43, 1'b0));
        play_items();

        // no room for any column
        program_frame(11'd3, 11'd160, 11'd240);
        text_items.push_back(glyph_item(KIND_CHAR, 8'h57, 1'b0));
        text_items.push_back(glyph_item(KIND_BLANK, 8'h00, 1'b0));
        text_items.push_back(glyph_item(KIND_START, 8'h00, 1'b0));
        play_items();

        for (int s = 0; s < 7; s++) begin
            case (s)
                0: program_frame(11'd240, 11'd160, 11'd240);
                1: program_frame(11'd2047, 11'd2047, 11'd2047);
                2: program_frame(11'd10, 11'd40, 11'd1);
                3: program_frame(11'd1280, 11'd1024, 11'd1280);
                4: program_frame(11'd64, 11'd31, 11'd100);
                default: begin
                    w = $urandom_range(10, 1280);
                    program_frame(11'(w), 11'($urandom_range(13, 1024)),
                                  11'($urandom_range(w, 2047)));
                end
            endcase
            if (s == 0) pressure_go = 1'b1;
            for (int k = 0; k < 27; k++) begin
                roll = $urandom_range(0, 99);
                code = $urandom_range(0, 1) ? 8'($urandom_range(8'h20, 8'h7F)) : 8'($urandom);
                eol = ($urandom_range(0, 5) == 0);
                if (roll < 74) begin
                    text_items.push_back(glyph_item(KIND_CHAR, code, eol));
                end else if (roll < 84) begin
                    text_items.push_back(glyph_item(KIND_BLANK, code, eol));
                end else if (roll < 92) begin
                    text_items.push_back(glyph_item(KIND_START, code, eol));
                end else if (roll < 95) begin
                    text_items.push_back(glyph_item(KIND_UNUSED, code, eol));
                end else begin
                    text_items.push_back(glyph_item(KIND_CHAR, code, 1'b1));
                end
            end
            play_items();
        end

        while (pixels_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("covered %0d text transactions (characters, blank lines, message starts)",
                 items_sent);
        $display("over %0d frame geometries, %0d pixel transactions compared",
                 settings_used, pixels_seen);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/trg_pkg.sv
src/trg_front.sv
src/trg_queue.sv
src/trg_back.sv
src/text_glyph_rasterizer.sv
bench/glyph_pixel_checker.sv
bench/tb_text_glyph_rasterizer.sv
